/* rtl/core/sbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound burst detector package
// Shared types, constants and log-domain helper functions.
// ----------------------------------------------------------------------------
package sbd_pkg;

    // Register indexes on the configuration port.
    localparam logic [2:0] CfgManualMode = 3'd0;
    localparam logic [2:0] CfgManualThr  = 3'd1;
    localparam logic [2:0] CfgMinThr     = 3'd2;
    localparam logic [2:0] CfgRise       = 3'd3;
    localparam logic [2:0] CfgRelease    = 3'd4;
    localparam logic [2:0] CfgFloor      = 3'd5;

    localparam int CfgAddrWidth = 3;
    localparam int CfgDataWidth = 12;
    localparam int LevelWidth   = 12;
    localparam int MarginWidth  = 10;
    localparam int SumWidth     = 16;
    localparam int CntWidth     = 8;
    localparam int BurstWidth   = 16;
    localparam int WinWidth     = 32;
    localparam int LogAddSize   = 22;
    localparam int QueueDepth   = 2;

    localparam int BaselineWindowsDefault = 32;

    // Reset values of the configuration registers and of the level state.
    localparam logic signed [LevelWidth-1:0]  ManualThrReset = -12'sd960;
    localparam logic signed [LevelWidth-1:0]  MinThrReset    = -12'sd960;
    localparam logic        [MarginWidth-1:0] RiseReset      = 10'd160;
    localparam logic        [MarginWidth-1:0] ReleaseReset   = 10'd48;
    localparam logic signed [LevelWidth-1:0]  FloorReset     = -12'sd1920;

    typedef struct packed {
        logic                          manual_mode;
        logic signed [LevelWidth-1:0]  manual_thr;
        logic signed [LevelWidth-1:0]  min_thr;
        logic        [MarginWidth-1:0] rise;
        logic        [MarginWidth-1:0] release_lvl;
    } t_sbd_cfg;

    // One classified window as handed from the front to the back.
    typedef struct packed {
        logic signed [LevelWidth-1:0] level;
        logic                         evaluate;
        logic                         base_done;
        logic signed [LevelWidth-1:0] base_level;
    } t_sbd_entry;

    // Correction term 160*log10(1 + 10^(-k/10)), in 1/16 dB.
    function automatic logic [5:0] logadd_tab(input logic [4:0] k);
        logic [5:0] v;
        case (k)
            5'd0:  v = 6'd48;
            5'd1:  v = 6'd41;
            5'd2:  v = 6'd34;
            5'd3:  v = 6'd28;
            5'd4:  v = 6'd23;
            5'd5:  v = 6'd19;
            5'd6:  v = 6'd16;
            5'd7:  v = 6'd13;
            5'd8:  v = 6'd10;
            5'd9:  v = 6'd8;
            5'd10: v = 6'd7;
            5'd11: v = 6'd5;
            5'd12: v = 6'd4;
            5'd13: v = 6'd3;
            5'd14: v = 6'd3;
            5'd15: v = 6'd2;
            5'd16: v = 6'd2;
            5'd17: v = 6'd1;
            5'd18: v = 6'd1;
            5'd19: v = 6'd1;
            5'd20: v = 6'd1;
            5'd21: v = 6'd1;
            default: v = 6'd0;
        endcase
        return v;
    endfunction

    // Power-domain sum of two levels given in dB.
    function automatic logic signed [SumWidth-1:0] logadd(
        input logic signed [SumWidth-1:0] a,
        input logic signed [SumWidth-1:0] b
    );
        logic signed [SumWidth-1:0] hi;
        logic signed [SumWidth-1:0] lo;
        logic        [SumWidth:0]   diff;
        logic        [SumWidth:0]   k;
        hi   = (a > b) ? a : b;
        lo   = (a > b) ? b : a;
        diff = {hi[SumWidth-1], hi} - {lo[SumWidth-1], lo};
        k    = (diff + (SumWidth+1)'(8)) >> 4;
        if (k < (SumWidth+1)'(LogAddSize)) begin
            return hi + SumWidth'(logadd_tab(k[4:0]));
        end
        return hi;
    endfunction

    // Log-sum of n equal 0 dB terms, folded at elaboration.
    function automatic logic signed [SumWidth-1:0] count_offset(input int n);
        logic signed [SumWidth-1:0] acc;
        int i;
        acc = '0;
        for (i = 1; i < n; i++) begin
            acc = logadd(acc, '0);
        end
        return acc;
    endfunction

    // Clamp a wide signed value to the 12-bit level range.
    function automatic logic signed [LevelWidth-1:0] sat12(input logic signed [17:0] x);
        if (x > 18'sd2047) begin
            return 12'sd2047;
        end
        if (x < -18'sd2048) begin
            return -12'sd2048;
        end
        return x[LevelWidth-1:0];
    endfunction

endpackage

/* rtl/core/sbd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound burst detector front end
// Accepts window levels, runs the baseline log-sum and tags each window.
// ----------------------------------------------------------------------------
module sbd_front #(
    parameter int BASELINE_WINDOWS = sbd_pkg::BaselineWindowsDefault
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_manual_mode,
    input  logic                                  i_accept,
    input  logic signed [sbd_pkg::LevelWidth-1:0] i_level,
    output sbd_pkg::t_sbd_entry                   o_entry
);

    localparam logic signed [sbd_pkg::SumWidth-1:0] Offset =
        sbd_pkg::count_offset(BASELINE_WINDOWS);
    localparam logic [sbd_pkg::CntWidth-1:0] NumWindows =
        sbd_pkg::CntWidth'(BASELINE_WINDOWS);

    logic        [sbd_pkg::CntWidth-1:0]   r_cnt, n_cnt;
    logic signed [sbd_pkg::SumWidth-1:0]   r_sum, n_sum;
    logic                                  r_done, n_done;
    logic signed [sbd_pkg::LevelWidth-1:0] r_base, n_base;
    logic signed [sbd_pkg::SumWidth-1:0]   level_w;
    logic signed [17:0]                    base_diff;

    assign level_w   = sbd_pkg::SumWidth'(i_level);
    assign base_diff = 18'(n_sum) - 18'(Offset);

    always_comb begin
        n_cnt  = r_cnt;
        n_sum  = r_sum;
        n_done = r_done;
        n_base = r_base;
        if (!r_done) begin
            n_sum  = (r_cnt == '0) ? level_w : sbd_pkg::logadd(r_sum, level_w);
            n_cnt  = r_cnt + 1'b1;
            if (n_cnt >= NumWindows) begin
                n_done = 1'b1;
                n_base = sbd_pkg::sat12(base_diff);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_sum  <= sbd_pkg::SumWidth'(sbd_pkg::FloorReset);
            r_done <= 1'b0;
            r_base <= sbd_pkg::FloorReset;
        end else if (i_accept) begin
            r_cnt  <= n_cnt;
            r_sum  <= n_sum;
            r_done <= n_done;
            r_base <= n_base;
        end
    end

    // Baseline windows are judged only when the manual threshold is in use.
    always_comb begin
        o_entry.level      = i_level;
        o_entry.evaluate   = r_done || i_manual_mode;
        o_entry.base_done  = n_done;
        o_entry.base_level = n_base;
    end

endmodule

/* rtl/core/sbd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound burst detector queue
// Short register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module sbd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sbd_pkg::t_sbd_entry i_entry,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output sbd_pkg::t_sbd_entry o_entry
);

    localparam int PtrWidth = $clog2(sbd_pkg::QueueDepth);

    sbd_pkg::t_sbd_entry        r_mem [sbd_pkg::QueueDepth];
    logic [PtrWidth-1:0]        r_wptr;
    logic [PtrWidth-1:0]        r_rptr;
    logic [PtrWidth:0]          r_count;

    assign o_full  = (r_count == (PtrWidth+1)'(sbd_pkg::QueueDepth));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/sbd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound burst detector back end
// Peak tracking, threshold selection and hysteresis burst counting.
// ----------------------------------------------------------------------------
module sbd_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  sbd_pkg::t_sbd_cfg                     i_cfg,
    input  logic                                  i_q_valid,
    input  sbd_pkg::t_sbd_entry                   i_q_entry,
    output logic                                  o_q_pop,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_burst_active,
    output logic [sbd_pkg::BurstWidth-1:0]        o_burst_total,
    output logic signed [sbd_pkg::LevelWidth-1:0] o_peak_level,
    output logic signed [sbd_pkg::LevelWidth-1:0] o_threshold_level,
    output logic                                  o_baseline_done,
    output logic signed [sbd_pkg::LevelWidth-1:0] o_baseline_level,
    output logic [sbd_pkg::WinWidth-1:0]          o_window_total
);

    localparam int LW = sbd_pkg::LevelWidth;

    logic                          r_valid;
    logic                          r_burst, n_burst;
    logic [sbd_pkg::BurstWidth-1:0] r_bcnt, n_bcnt;
    logic signed [LW-1:0]          r_peak, n_peak;
    logic signed [LW-1:0]          r_thr;
    logic                          r_done;
    logic signed [LW-1:0]          r_base;
    logic [sbd_pkg::WinWidth-1:0]  r_wcnt;

    logic signed [LW:0]            auto_thr;
    logic signed [LW:0]            raised_thr;
    logic signed [LW-1:0]          thr;
    logic signed [LW:0]            release_thr;

    // The result registers double as detector state, so an item is taken
    // from the queue only once the previous result has left.
    assign o_q_pop = i_q_valid && (!r_valid || i_ready);

    always_comb begin
        auto_thr   = (LW+1)'(i_q_entry.base_level) + (LW+1)'(i_cfg.rise);
        raised_thr = (auto_thr < (LW+1)'(i_cfg.min_thr)) ? (LW+1)'(i_cfg.min_thr)
                                                        : auto_thr;
        thr        = i_cfg.manual_mode ? i_cfg.manual_thr : sbd_pkg::sat12(18'(raised_thr));
        release_thr = (LW+1)'(thr) - (LW+1)'(i_cfg.release_lvl);
    end

    always_comb begin
        n_burst = r_burst;
        n_bcnt  = r_bcnt;
        n_peak  = r_peak;
        if (i_q_entry.evaluate) begin
            if (i_q_entry.level > r_peak) begin
                n_peak = i_q_entry.level;
            end
            if (!r_burst) begin
                if (i_q_entry.level > thr) begin
                    n_burst = 1'b1;
                    if (r_bcnt != '1) begin
                        n_bcnt = r_bcnt + 1'b1;
                    end
                end
            end else if ((LW+1)'(i_q_entry.level) < release_thr) begin
                n_burst = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_burst <= 1'b0;
            r_bcnt  <= '0;
            r_peak  <= sbd_pkg::FloorReset;
            r_thr   <= '0;
            r_done  <= 1'b0;
            r_base  <= sbd_pkg::FloorReset;
            r_wcnt  <= '0;
        end else begin
            if (o_q_pop) begin
                r_valid <= 1'b1;
                r_burst <= n_burst;
                r_bcnt  <= n_bcnt;
                r_peak  <= n_peak;
                r_thr   <= thr;
                r_done  <= i_q_entry.base_done;
                r_base  <= i_q_entry.base_level;
                r_wcnt  <= r_wcnt + 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid           = r_valid;
    assign o_burst_active    = r_burst;
    assign o_burst_total     = r_bcnt;
    assign o_peak_level      = r_peak;
    assign o_threshold_level = r_thr;
    assign o_baseline_done   = r_done;
    assign o_baseline_level  = r_base;
    assign o_window_total    = r_wcnt;

endmodule

/* rtl/core/sound_burst_detector.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound burst detector
// Counts sound bursts in a stream of per-window RMS levels.
// ----------------------------------------------------------------------------
// The block takes one RMS level per window, in 1/16 dBFS, and returns one
// result request per window. The first BASELINE_WINDOWS levels are summed in
// the power domain with a small log-add table, and the baseline is that sum
// minus the log-sum of as many 0 dB terms. In automatic mode the threshold is
// the baseline plus rise_level, raised to min_threshold, and the baseline
// windows are not judged; in manual mode manual_threshold is used from the
// first window on. A burst starts when the level exceeds the threshold and
// ends when it falls below the threshold minus release_level; burst starts
// are counted into a saturating 16-bit counter. The block sustains one
// request per clock cycle while the queue has room, limited by the log-add
// update of the front end; an accepted request goes into the two-entry queue
// and then into the result registers once the previous result has left them.
// The input keeps flowing while a finished result waits, until the queue
// fills. Writing floor_level has no effect: baseline and peak always restart
// from -120 dBFS at reset. The user must write configuration only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sound_burst_detector #(
    parameter int BASELINE_WINDOWS = sbd_pkg::BaselineWindowsDefault
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // Configuration write port.
    input  logic                                    i_cfg_we,
    input  logic [sbd_pkg::CfgAddrWidth-1:0]        i_cfg_addr,
    input  logic [sbd_pkg::CfgDataWidth-1:0]        i_cfg_data,
    // Input channel.
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [sbd_pkg::LevelWidth-1:0]   i_level,
    // Result channel.
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic                                    o_burst_active,
    output logic [sbd_pkg::BurstWidth-1:0]          o_burst_total,
    output logic signed [sbd_pkg::LevelWidth-1:0]   o_peak_level,
    output logic signed [sbd_pkg::LevelWidth-1:0]   o_threshold_level,
    output logic                                    o_baseline_done,
    output logic signed [sbd_pkg::LevelWidth-1:0]   o_baseline_level,
    output logic [sbd_pkg::WinWidth-1:0]            o_window_total
);

    sbd_pkg::t_sbd_cfg   r_cfg;
    sbd_pkg::t_sbd_entry front_entry;
    sbd_pkg::t_sbd_entry q_entry;
    logic                q_full;
    logic                q_valid;
    logic                q_pop;
    logic                accept;

    // A request is taken whenever the queue has room.
    assign o_ready = !q_full;
    assign accept  = i_valid && o_ready;

    // Configuration registers. The floor level index is accepted but not
    // stored, since the level state always resets to its fixed floor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.manual_mode <= 1'b0;
            r_cfg.manual_thr  <= sbd_pkg::ManualThrReset;
            r_cfg.min_thr     <= sbd_pkg::MinThrReset;
            r_cfg.rise        <= sbd_pkg::RiseReset;
            r_cfg.release_lvl <= sbd_pkg::ReleaseReset;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sbd_pkg::CfgManualMode: r_cfg.manual_mode <= i_cfg_data[0];
                sbd_pkg::CfgManualThr:  r_cfg.manual_thr  <= i_cfg_data;
                sbd_pkg::CfgMinThr:     r_cfg.min_thr     <= i_cfg_data;
                sbd_pkg::CfgRise:
                    r_cfg.rise        <= i_cfg_data[sbd_pkg::MarginWidth-1:0];
                sbd_pkg::CfgRelease:
                    r_cfg.release_lvl <= i_cfg_data[sbd_pkg::MarginWidth-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: baseline accumulation and window classification.
    sbd_front #(
        .BASELINE_WINDOWS (BASELINE_WINDOWS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_manual_mode (r_cfg.manual_mode),
        .i_accept      (accept),
        .i_level       (i_level),
        .o_entry       (front_entry)
    );

    // Decoupling queue between the two halves.
    sbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    // Back end: peak, threshold, hysteresis and the result registers.
    sbd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_q_valid         (q_valid),
        .i_q_entry         (q_entry),
        .o_q_pop           (q_pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_burst_active    (o_burst_active),
        .o_burst_total     (o_burst_total),
        .o_peak_level      (o_peak_level),
        .o_threshold_level (o_threshold_level),
        .o_baseline_done   (o_baseline_done),
        .o_baseline_level  (o_baseline_level),
        .o_window_total    (o_window_total)
    );

endmodule
